[hdl/ssp_pkg.sv]
`timescale 1ns / 1ps

package ssp_pkg;

    // Nesting depth counter width and its saturation value
    localparam int DEPTH_WIDTH = 8;
    localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = {DEPTH_WIDTH{1'b1}};

    // Keyword buffer: up to five word characters, letters in upper case
    localparam int WORD_CHARS = 5;
    localparam int WORD_BITS  = WORD_CHARS * 8;
    localparam logic [2:0] WORD_LEN_MAX  = 3'd5;
    localparam logic [2:0] WORD_TOO_LONG = 3'd6;
    localparam logic [2:0] LEN_BEGIN     = 3'd5;
    localparam logic [2:0] LEN_END       = 3'd3;
    localparam logic [WORD_BITS-1:0] KW_BEGIN = 40'h424547494E;
    localparam logic [WORD_BITS-1:0] KW_END   = 40'h0000454E44;

    // Byte codes
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Queue between classifier and scanner
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_SQUOTE,
        CLS_DQUOTE,
        CLS_DASH,
        CLS_SLASH,
        CLS_STAR,
        CLS_SEMI,
        CLS_NEWLINE
    } char_class_t;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SQUOTE = 3'd1,
        MODE_DQUOTE = 3'd2,
        MODE_LINE   = 3'd3,
        MODE_BLOCK  = 3'd4
    } scan_mode_t;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_DASH  = 2'd1,
        PEND_SLASH = 2'd2
    } opener_t;

    // One classified byte as it travels through the queue
    typedef struct packed {
        logic [7:0]  text_byte;
        logic [7:0]  upper_byte;
        logic        last;
        logic        is_word;
        logic        is_space;
        char_class_t cls;
    } item_t;

endpackage

[hdl/ssp_front.sv]
`timescale 1ns / 1ps

module ssp_front (
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_text_byte,
    input  logic            s_end_of_text,
    input  logic            queue_full,
    output logic            push,
    output ssp_pkg::item_t  item
);
    import ssp_pkg::*;

    // Accept whenever the queue has room
    assign s_ready = ~queue_full;
    assign push    = s_valid & ~queue_full;

    // Classify the incoming byte
    always_comb begin
        item            = '0;
        item.text_byte  = s_text_byte;
        item.last       = s_end_of_text;
        item.is_word    = (s_text_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]})
                          || (s_text_byte == CHAR_UNDER);
        item.is_space   = (s_text_byte == CHAR_SPACE) || (s_text_byte inside {[8'h09:8'h0D]});
        item.upper_byte = (s_text_byte inside {[8'h61:8'h7A]}) ? s_text_byte - CASE_OFFSET
                                                                : s_text_byte;
        case (s_text_byte)
            CHAR_SQUOTE:  item.cls = CLS_SQUOTE;
            CHAR_DQUOTE:  item.cls = CLS_DQUOTE;
            CHAR_DASH:    item.cls = CLS_DASH;
            CHAR_SLASH:   item.cls = CLS_SLASH;
            CHAR_STAR:    item.cls = CLS_STAR;
            CHAR_SEMI:    item.cls = CLS_SEMI;
            CHAR_NEWLINE: item.cls = CLS_NEWLINE;
            default:      item.cls = CLS_OTHER;
        endcase
    end

endmodule

[hdl/ssp_queue.sv]
`timescale 1ns / 1ps

module ssp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ssp_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ssp_pkg::item_t  head_item
);
    import ssp_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hdl/ssp_scanner.sv]
`timescale 1ns / 1ps

module ssp_scanner (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  ssp_pkg::item_t  head_item,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_byte_out,
    output logic            m_statement_end,
    output logic            m_text_done
);
    import ssp_pkg::*;

    scan_mode_t                mode_reg, mode_next;
    logic                      quote_pend_reg, quote_pend_next;
    logic                      star_reg, star_next;
    opener_t                   opener_reg, opener_next;
    logic [WORD_BITS-1:0]      letters_reg, letters_next;
    logic [2:0]                word_len_reg, word_len_next;
    logic [DEPTH_WIDTH-1:0]    depth_reg, depth_next;
    logic                      content_reg, content_next;

    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      out_end_reg;
    logic                      out_done_reg;

    logic                      run_normal;
    logic                      quote_match;
    logic                      end_flag;

    // Take the queue head when the output register is free or draining
    assign pop = head_valid & (~out_valid_reg | m_ready);

    assign m_valid         = out_valid_reg;
    assign m_byte_out      = out_byte_reg;
    assign m_statement_end = out_end_reg;
    assign m_text_done     = out_done_reg;

    // Scan state transition for the head byte
    always_comb begin
        mode_next       = mode_reg;
        quote_pend_next = quote_pend_reg;
        star_next       = star_reg;
        opener_next     = opener_reg;
        letters_next    = letters_reg;
        word_len_next   = word_len_reg;
        depth_next      = depth_reg;
        content_next    = content_reg | ~head_item.is_space;
        run_normal      = 1'b0;
        end_flag        = 1'b0;
        quote_match     = (mode_reg == MODE_SQUOTE) ? (head_item.cls == CLS_SQUOTE)
                                                    : (head_item.cls == CLS_DQUOTE);

        case (mode_reg)
            MODE_LINE: begin
                if (head_item.cls == CLS_NEWLINE) begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_BLOCK: begin
                if (star_reg && head_item.cls == CLS_SLASH) begin
                    mode_next = MODE_NORMAL;
                    star_next = 1'b0;
                end else begin
                    star_next = (head_item.cls == CLS_STAR);
                end
            end
            MODE_SQUOTE, MODE_DQUOTE: begin
                if (quote_pend_reg) begin
                    quote_pend_next = 1'b0;
                    if (!quote_match) begin
                        mode_next  = MODE_NORMAL;
                        run_normal = 1'b1;
                    end
                end else if (quote_match) begin
                    quote_pend_next = 1'b1;
                end
            end
            default: begin
                mode_next   = MODE_NORMAL;
                opener_next = PEND_NONE;
                if (opener_reg == PEND_DASH && head_item.cls == CLS_DASH) begin
                    mode_next = MODE_LINE;
                end else if (opener_reg == PEND_SLASH && head_item.cls == CLS_STAR) begin
                    mode_next = MODE_BLOCK;
                    star_next = 1'b0;
                end else begin
                    run_normal = 1'b1;
                end
            end
        endcase

        // Normal-mode byte: word collection, keyword depth, openers, semicolon
        if (run_normal) begin
            if (head_item.is_word) begin
                if (word_len_reg < WORD_LEN_MAX) begin
                    letters_next  = {letters_reg[WORD_BITS-9:0], head_item.upper_byte};
                    word_len_next = word_len_reg + 1'b1;
                end else begin
                    word_len_next = WORD_TOO_LONG;
                end
            end else begin
                if (word_len_reg == LEN_BEGIN && letters_reg == KW_BEGIN) begin
                    if (depth_reg != DEPTH_MAX) begin
                        depth_next = depth_reg + 1'b1;
                    end
                end else if (word_len_reg == LEN_END && letters_reg == KW_END) begin
                    if (depth_reg != '0) begin
                        depth_next = depth_reg - 1'b1;
                    end
                end
                letters_next  = '0;
                word_len_next = '0;
                case (head_item.cls)
                    CLS_SQUOTE: mode_next   = MODE_SQUOTE;
                    CLS_DQUOTE: mode_next   = MODE_DQUOTE;
                    CLS_DASH:   opener_next = PEND_DASH;
                    CLS_SLASH:  opener_next = PEND_SLASH;
                    CLS_SEMI:   end_flag    = (depth_next == '0);
                    default:    end_flag    = 1'b0;
                endcase
            end
        end

        if (end_flag) begin
            content_next = 1'b0;
        end

        // Last byte: flush a non-blank remainder and return to reset state
        if (head_item.last) begin
            end_flag        = end_flag | content_next;
            mode_next       = MODE_NORMAL;
            quote_pend_next = 1'b0;
            star_next       = 1'b0;
            opener_next     = PEND_NONE;
            letters_next    = '0;
            word_len_next   = '0;
            depth_next      = '0;
            content_next    = 1'b0;
        end
    end

    // Scan state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_NORMAL;
            quote_pend_reg <= 1'b0;
            star_reg       <= 1'b0;
            opener_reg     <= PEND_NONE;
            letters_reg    <= '0;
            word_len_reg   <= '0;
            depth_reg      <= '0;
            content_reg    <= 1'b0;
        end else if (pop) begin
            mode_reg       <= mode_next;
            quote_pend_reg <= quote_pend_next;
            star_reg       <= star_next;
            opener_reg     <= opener_next;
            letters_reg    <= letters_next;
            word_len_reg   <= word_len_next;
            depth_reg      <= depth_next;
            content_reg    <= content_next;
        end
    end

    // Output register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            out_byte_reg <= head_item.text_byte;
            out_end_reg  <= end_flag;
            out_done_reg <= head_item.last;
        end
    end

endmodule

[hdl/sql_statement_splitter.sv]
`timescale 1ns / 1ps
// Each byte is registered in a queue entry and then in the output register,
// which drives the result port. Throughput: one byte per cycle while m_ready
// stays high; the scanner decides each byte combinationally, and a 2-entry
// queue plus the output register keep both sides moving.
// Reset: synchronous, active low; clears the queue, the output valid and all
// scan state (normal mode, depth zero). No clearing pass.

module sql_statement_splitter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte_out,
    output logic       m_statement_end,
    output logic       m_text_done
);
    import ssp_pkg::*;

    item_t push_item;
    item_t head_item;
    logic  push;
    logic  pop;
    logic  queue_full;
    logic  head_valid;

    ssp_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .queue_full    (queue_full),
        .push          (push),
        .item          (push_item)
    );

    ssp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    ssp_scanner u_scanner (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_item       (head_item),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_out      (m_byte_out),
        .m_statement_end (m_statement_end),
        .m_text_done     (m_text_done)
    );

endmodule

[hdl/ssp_checker.sv]
`timescale 1ns / 1ps

module ssp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_text_byte,
    input logic       s_end_of_text,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_byte_out,
    input logic       m_statement_end,
    input logic       m_text_done
);
    import ssp_pkg::*;

    logic out_is_space;
    assign out_is_space = (m_byte_out == CHAR_SPACE) ||
                          (m_byte_out >= 8'h09 && m_byte_out <= 8'h0D);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_out) &&
        $stable(m_statement_end) && $stable(m_text_done))
        else $error("stalled result changed");

    // Inside the text, only a semicolon ends a statement
    a_end_on_semi: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_statement_end && !m_text_done |-> m_byte_out == CHAR_SEMI)
        else $error("statement end on a non-semicolon byte");

    // A last byte that is not blank always closes a statement
    a_final_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_text_done && !out_is_space |-> m_statement_end)
        else $error("non-blank last byte did not end a statement");

endmodule

bind sql_statement_splitter ssp_checker u_ssp_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ssp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_BYTES = 1300;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PAREN = 8'h28;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last;
    } text_item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       statement_end;
        logic       text_done;
    } mark_t;

    // DUT ports
    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_byte     = 8'h00;
    logic       s_end_of_text   = 1'b0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic [7:0] m_byte_out;
    logic       m_statement_end;
    logic       m_text_done;

    // Stimulus and scoreboard
    text_item_t pending_bytes[$];
    mark_t      predicted_marks[$];
    logic [7:0] draft[$];
    string      near_kw[7] = '{"BEGI", "BEGINS", "EN", "ENDS", "XEND", "B", "E_ND"};

    int  send_idle  = 22;
    int  recv_idle  = 68;
    bit  squeeze    = 1'b0;
    bit  hold_off   = 1'b0;
    bit  took_input = 1'b0;
    int  accepted   = 0;
    int  fails      = 0;
    int  cycles     = 0;
    int  stmt_ends  = 0;
    int  texts_seen = 0;
    int  peak_depth = 0;

    // Predictor state
    scan_mode_t             mode_q;
    logic                   qpend_q;
    logic                   star_q;
    opener_t                opener_q;
    logic [WORD_BITS-1:0]   word_q;
    logic [2:0]             wlen_q;
    logic [DEPTH_WIDTH-1:0] depth_q;
    logic                   content_q;

    sql_statement_splitter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .s_end_of_text   (s_end_of_text),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_out      (m_byte_out),
        .m_statement_end (m_statement_end),
        .m_text_done     (m_text_done)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_scan();
        mode_q    = MODE_NORMAL;
        qpend_q   = 1'b0;
        star_q    = 1'b0;
        opener_q  = PEND_NONE;
        word_q    = '0;
        wlen_q    = '0;
        depth_q   = '0;
        content_q = 1'b0;
    endfunction

    // Plain-text byte: word tracking, keyword depth, literal/comment entry, semicolon
    function automatic logic scan_plain(input logic [7:0] b);
        logic [7:0] up;
        if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
            (b >= "0" && b <= "9") || b == CHAR_UNDER) begin
            if (wlen_q < WORD_LEN_MAX) begin
                up = (b >= "a" && b <= "z") ? b - CASE_OFFSET : b;
                word_q = {word_q[WORD_BITS-9:0], up};
                wlen_q = wlen_q + 3'd1;
            end else begin
                wlen_q = WORD_TOO_LONG;
            end
            return 1'b0;
        end
        // word boundary: judge the finished word
        if (wlen_q == LEN_BEGIN && word_q == KW_BEGIN) begin
            if (depth_q != DEPTH_MAX) depth_q = depth_q + 1'b1;
            if (int'(depth_q) > peak_depth) peak_depth = int'(depth_q);
        end else if (wlen_q == LEN_END && word_q == KW_END) begin
            if (depth_q != '0) depth_q = depth_q - 1'b1;
        end
        word_q = '0;
        wlen_q = '0;
        if (b == CHAR_SQUOTE) mode_q = MODE_SQUOTE;
        else if (b == CHAR_DQUOTE) mode_q = MODE_DQUOTE;
        else if (b == CHAR_DASH) opener_q = PEND_DASH;
        else if (b == CHAR_SLASH) opener_q = PEND_SLASH;
        else if (b == CHAR_SEMI && depth_q == '0) return 1'b1;
        return 1'b0;
    endfunction

    // Expected pass-through byte and statement-end flag for one input byte
    function automatic mark_t predict_boundary(input logic [7:0] b, input logic last);
        mark_t      r;
        logic       ends;
        logic [7:0] closer;
        ends   = 1'b0;
        closer = (mode_q == MODE_SQUOTE) ? CHAR_SQUOTE : CHAR_DQUOTE;
        if (!(b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))) content_q = 1'b1;
        case (mode_q)
            MODE_LINE: begin
                if (b == CHAR_NEWLINE) mode_q = MODE_NORMAL;
            end
            MODE_BLOCK: begin
                if (star_q && b == CHAR_SLASH) begin
                    mode_q = MODE_NORMAL;
                    star_q = 1'b0;
                end else begin
                    star_q = (b == CHAR_STAR);
                end
            end
            MODE_SQUOTE, MODE_DQUOTE: begin
                if (qpend_q) begin
                    qpend_q = 1'b0;
                    if (b != closer) begin
                        mode_q = MODE_NORMAL;
                        ends   = scan_plain(b);
                    end
                end else if (b == closer) begin
                    qpend_q = 1'b1;
                end
            end
            default: begin
                mode_q = MODE_NORMAL;
                if (opener_q == PEND_DASH && b == CHAR_DASH) begin
                    opener_q = PEND_NONE;
                    mode_q   = MODE_LINE;
                end else if (opener_q == PEND_SLASH && b == CHAR_STAR) begin
                    opener_q = PEND_NONE;
                    mode_q   = MODE_BLOCK;
                    star_q   = 1'b0;
                end else begin
                    opener_q = PEND_NONE;
                    ends     = scan_plain(b);
                end
            end
        endcase
        if (ends) content_q = 1'b0;
        // last byte: flush any content, then back to reset state
        if (last) begin
            if (content_q) ends = 1'b1;
            clear_scan();
        end
        r.byte_out      = b;
        r.statement_end = ends;
        r.text_done     = last;
        return r;
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    endfunction

    // Random letter case per character
    function automatic void add_mixed_case(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + CASE_OFFSET;
            draft.push_back(c);
        end
    endfunction

    // Move the drafted text into the send queue, marking its final byte
    function automatic void flush_draft();
        for (int i = 0; i < draft.size(); i++)
            pending_bytes.push_back('{text_byte: draft[i], last: (i == draft.size() - 1)});
        draft.delete();
    endfunction

    // Sender: new transfer offered at the falling edge, held until taken
    always @(negedge aclk) begin
        text_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !took_input)) begin
            took_input = 1'b0;
            if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                nxt = pending_bytes.pop_front();
                s_valid       <= 1'b1;
                s_text_byte   <= nxt.text_byte;
                s_end_of_text <= nxt.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with a long hold-off during the pressure phase
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
    end

    initial begin
        wait (squeeze);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Monitor: check result transfers, then predict for input transfers
    always @(posedge aclk) begin
        mark_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted_marks.size() == 0) begin
                    $error("unexpected result transfer: byte_out %0h", m_byte_out);
                    fails++;
                end else begin
                    want = predicted_marks.pop_front();
                    if (m_byte_out !== want.byte_out) begin
                        $error("byte_out mismatch: expected %0h, actual %0h",
                               want.byte_out, m_byte_out);
                        fails++;
                    end
                    if (m_statement_end !== want.statement_end) begin
                        $error("statement_end mismatch: expected %0b, actual %0b",
                               want.statement_end, m_statement_end);
                        fails++;
                    end
                    if (m_text_done !== want.text_done) begin
                        $error("text_done mismatch: expected %0b, actual %0b",
                               want.text_done, m_text_done);
                        fails++;
                    end
                    if (want.statement_end) stmt_ends++;
                    if (want.text_done) texts_seen++;
                end
            end
            if (s_valid && s_ready) begin
                predicted_marks.push_back(predict_boundary(s_text_byte, s_end_of_text));
                accepted++;
                took_input = 1'b1;
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Run limit of %0d cycles hit with %0d results outstanding",
                     LIMIT_CYCLES, predicted_marks.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int         total;
        int         base;
        int         pick;
        int         n;
        logic [7:0] q;
        clear_scan();

        // Directed: END at depth zero, a word too long to be BEGIN
        add_str("end;begins;");
        flush_draft();
        // Escaped quote, semicolon inside a literal, lone dash and slash, top byte
        draft.push_back(CHAR_SQUOTE);
        draft.push_back(CHAR_SQUOTE);
        draft.push_back(CHAR_SQUOTE);
        draft.push_back(CHAR_SEMI);
        draft.push_back(CHAR_SQUOTE);
        draft.push_back(CHAR_DASH);
        draft.push_back(CHAR_SLASH);
        draft.push_back(8'hFF);
        flush_draft();
        // Zero byte alone is content
        draft.push_back(8'h00);
        flush_draft();
        // Whitespace-only text: no statement end
        add_str(" \t\n");
        flush_draft();
        // Quote left open on the last byte
        draft.push_back(CHAR_DQUOTE);
        flush_draft();

        // Nesting: semicolons hidden until every BEGIN is closed, extra END stays at zero
        for (int i = 0; i < 12; i++) add_str("Begin ");
        add_str("x;");
        for (int i = 0; i < 13; i++) add_str("end ");
        add_str(";x");
        flush_draft();

        // Random texts built from SQL-like tokens plus noise
        base = pending_bytes.size();
        while (pending_bytes.size() - base < RANDOM_BYTES) begin
            n = $urandom_range(1, 16);
            for (int t = 0; t < n; t++) begin
                pick = $urandom_range(0, 99);
                if (pick < 15 || (pick >= 15 && pick < 30)) begin
                    // keyword, usually followed by a separator
                    add_mixed_case(pick < 15 ? "BEGIN" : "END");
                    if ($urandom_range(0, 99) < 80) begin
                        case ($urandom_range(0, 3))
                            0: draft.push_back(CHAR_SPACE);
                            1: draft.push_back(CHAR_NEWLINE);
                            2: draft.push_back(CHAR_SEMI);
                            default: draft.push_back(CHAR_PAREN);
                        endcase
                    end
                end else if (pick < 45) begin
                    if ($urandom_range(0, 2) == 0) begin
                        add_mixed_case(near_kw[$urandom_range(0, 6)]);
                    end else begin
                        for (int k = $urandom_range(1, 8); k > 0; k--) begin
                            q = 8'($urandom_range(0, 62));
                            if (q < 26) draft.push_back("A" + q);
                            else if (q < 52) draft.push_back("a" + q - 8'd26);
                            else if (q < 62) draft.push_back("0" + q - 8'd52);
                            else draft.push_back(CHAR_UNDER);
                        end
                    end
                    draft.push_back(CHAR_SPACE);
                end else if (pick < 55) begin
                    for (int k = $urandom_range(1, 3); k > 0; k--) begin
                        q = 8'($urandom_range(8, 13));
                        draft.push_back(q == 8 ? CHAR_SPACE : q);
                    end
                end else if (pick < 65) begin
                    draft.push_back(CHAR_SEMI);
                end else if (pick < 73) begin
                    // quoted literal with escapes; sometimes left open
                    q = $urandom_range(0, 1) ? CHAR_SQUOTE : CHAR_DQUOTE;
                    draft.push_back(q);
                    for (int k = $urandom_range(0, 5); k > 0; k--) begin
                        case ($urandom_range(0, 7))
                            0, 1: begin
                                draft.push_back(q);
                                draft.push_back(q);
                            end
                            2: draft.push_back(q == CHAR_SQUOTE ? CHAR_DQUOTE : CHAR_SQUOTE);
                            3: draft.push_back(CHAR_SEMI);
                            default: draft.push_back(8'($urandom_range(0, 255)));
                        endcase
                    end
                    if ($urandom_range(0, 99) < 85) draft.push_back(q);
                end else if (pick < 79) begin
                    // line comment
                    draft.push_back(CHAR_DASH);
                    draft.push_back(CHAR_DASH);
                    for (int k = $urandom_range(0, 6); k > 0; k--)
                        draft.push_back(8'($urandom_range(32, 126)));
                    if ($urandom_range(0, 99) < 85) draft.push_back(CHAR_NEWLINE);
                end else if (pick < 85) begin
                    // block comment with stray stars and slashes
                    draft.push_back(CHAR_SLASH);
                    draft.push_back(CHAR_STAR);
                    for (int k = $urandom_range(0, 6); k > 0; k--) begin
                        case ($urandom_range(0, 3))
                            0: draft.push_back(CHAR_STAR);
                            1: draft.push_back(CHAR_SLASH);
                            default: draft.push_back(8'($urandom_range(32, 126)));
                        endcase
                    end
                    if ($urandom_range(0, 99) < 85) begin
                        draft.push_back(CHAR_STAR);
                        draft.push_back(CHAR_SLASH);
                    end
                end else if (pick < 90) begin
                    draft.push_back($urandom_range(0, 1) ? CHAR_DASH : CHAR_SLASH);
                end else begin
                    draft.push_back(8'($urandom_range(0, 255)));
                end
            end
            flush_draft();
        end

        total = pending_bytes.size();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Swap the idle ratios, then run flat out with a receiver hold-off
        wait (accepted >= total / 3);
        send_idle = 68;
        recv_idle = 22;
        wait (accepted >= 2 * total / 3);
        send_idle = 0;
        recv_idle = 0;
        squeeze   = 1'b1;

        wait (accepted == total && predicted_marks.size() == 0);
        repeat (8) @(posedge aclk);

        $display("Scanned %0d bytes in %0d texts, %0d statement ends flagged",
                 total, texts_seen, stmt_ends);
        $display("Deepest nesting reached %0d", peak_depth);
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/ssp_pkg.sv
hdl/ssp_front.sv
hdl/ssp_queue.sv
hdl/ssp_scanner.sv
hdl/sql_statement_splitter.sv
hdl/ssp_checker.sv
tb/sv/tb.sv
